FILE: rtl/cfp_pkg.sv
// Shared types and constants for the position-to-CQI pipeline.
package cfp_pkg;

  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STATION_X     = 3'd0,
    REG_STATION_Y     = 3'd1,
    REG_TX_POWER      = 3'd2,
    REG_REFERENCE     = 3'd3,
    REG_SLOPE         = 3'd4,
    REG_NOISE_FLOOR   = 3'd5,
    REG_SINR_OFFSET   = 3'd6
  } reg_idx_t;

  localparam int TX_W      = 6;
  localparam int REF_W     = 7;
  localparam int SLOPE_W   = 6;
  localparam int NOISE_W   = 9;
  localparam int OFFSET_W  = 8;
  localparam int BASE_W    = 11;
  localparam int QUALITY_W = 8;

  localparam logic [TX_W-1:0]     TX_RESET     = 6'd46;
  localparam logic [REF_W-1:0]    REF_RESET    = 7'd30;
  localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 6'd30;
  localparam logic [NOISE_W-1:0]  NOISE_RESET  = 9'h19B;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd30;

  localparam int                  HLG_W            = 14;
  localparam logic [HLG_W-1:0]    HALF_LOG10_2_Q16 = 14'd9864;
  localparam int                  DIST_LOG_INT     = 4;
  localparam int                  MANT_W           = 32;
  localparam int                  MANT_FRAC        = 31;
  localparam int                  QSHIFT_EXTRA     = 14;
  localparam int                  BASE_SHIFT_EXTRA = 16;
  localparam logic [QUALITY_W-1:0] QUALITY_MAX     = 8'd240;

  typedef struct packed {
    logic valid;
    logic zero;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [BASE_W-1:0] base;
    logic [SLOPE_W-1:0]       slope;
  } qual_cfg_t;

endpackage

FILE: rtl/cfp_ifs.sv
// Request, result and register-write channel interfaces.
interface cfp_in_if #(parameter int POS_BITS = 16);
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;
  modport source(output valid, output pos_x, output pos_y, input ready);
  modport sink(input valid, input pos_x, input pos_y, output ready);
endinterface

interface cfp_out_if;
  logic                           valid;
  logic                           ready;
  logic [cfp_pkg::QUALITY_W-1:0]  quality;
  logic                           clamped;
  modport source(output valid, output quality, output clamped, input ready);
  modport sink(input valid, input quality, input clamped, output ready);
endinterface

interface cfp_cfg_if #(parameter int DATA_W = 16);
  logic                           valid;
  logic                           ready;
  logic [cfp_pkg::REG_IDX_W-1:0]  index;
  logic [DATA_W-1:0]              data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/cfp_regs.sv
// Configuration register file and derived link-budget constant.
module cfp_regs #(
  parameter int POS_BITS = 16,
  parameter int DATA_W   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [cfp_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]             wr_data,
  output logic [POS_BITS-1:0]           station_x,
  output logic [POS_BITS-1:0]           station_y,
  output cfp_pkg::qual_cfg_t            qcfg
);

  localparam int BW = cfp_pkg::BASE_W;

  logic [POS_BITS-1:0]              station_x_r;
  logic [POS_BITS-1:0]              station_y_r;
  logic [cfp_pkg::TX_W-1:0]         tx_r;
  logic [cfp_pkg::REF_W-1:0]        ref_r;
  logic [cfp_pkg::SLOPE_W-1:0]      slope_r;
  logic [cfp_pkg::NOISE_W-1:0]      noise_r;
  logic [cfp_pkg::OFFSET_W-1:0]     offset_r;
  cfp_pkg::qual_cfg_t               qcfg_r;
  logic signed [BW-1:0]             base_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_x_r <= '0;
      station_y_r <= '0;
      tx_r        <= cfp_pkg::TX_RESET;
      ref_r       <= cfp_pkg::REF_RESET;
      slope_r     <= cfp_pkg::SLOPE_RESET;
      noise_r     <= cfp_pkg::NOISE_RESET;
      offset_r    <= cfp_pkg::OFFSET_RESET;
    end else if (wr_en) begin
      case (wr_index)
        cfp_pkg::REG_STATION_X:   station_x_r <= wr_data[POS_BITS-1:0];
        cfp_pkg::REG_STATION_Y:   station_y_r <= wr_data[POS_BITS-1:0];
        cfp_pkg::REG_TX_POWER:    tx_r        <= wr_data[cfp_pkg::TX_W-1:0];
        cfp_pkg::REG_REFERENCE:   ref_r       <= wr_data[cfp_pkg::REF_W-1:0];
        cfp_pkg::REG_SLOPE:       slope_r     <= wr_data[cfp_pkg::SLOPE_W-1:0];
        cfp_pkg::REG_NOISE_FLOOR: noise_r     <= wr_data[cfp_pkg::NOISE_W-1:0];
        cfp_pkg::REG_SINR_OFFSET: offset_r    <= wr_data[cfp_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base_nxt = $signed({{(BW-cfp_pkg::TX_W){1'b0}}, tx_r})
             - $signed({{(BW-cfp_pkg::NOISE_W){noise_r[cfp_pkg::NOISE_W-1]}}, noise_r})
             - $signed({{(BW-cfp_pkg::OFFSET_W){offset_r[cfp_pkg::OFFSET_W-1]}}, offset_r})
             - $signed({{(BW-cfp_pkg::REF_W){1'b0}}, ref_r});
  end

  always_ff @(posedge clk) begin
    qcfg_r.base  <= base_nxt;
    qcfg_r.slope <= slope_r;
  end

  assign station_x = station_x_r;
  assign station_y = station_y_r;
  assign qcfg      = qcfg_r;

endmodule

FILE: rtl/cfp_dist.sv
// Squared distance pipeline: difference and magnitude, squares, sum.
module cfp_dist #(
  parameter int POS_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [POS_BITS-1:0]           pos_x,
  input  logic [POS_BITS-1:0]           pos_y,
  input  logic [POS_BITS-1:0]           station_x,
  input  logic [POS_BITS-1:0]           station_y,
  output cfp_pkg::pipe_ctl_t            ctl_o,
  output logic [2*POS_BITS:0]           sum_o
);

  localparam int DW    = POS_BITS + 1;
  localparam int SQ_W  = 2 * POS_BITS;
  localparam int SUM_W = 2 * POS_BITS + 1;

  logic [DW-1:0]       dx, dy, ndx, ndy;
  logic [POS_BITS-1:0] ax_nxt, ay_nxt;
  logic [POS_BITS-1:0] ax_r, ay_r;
  logic [SQ_W-1:0]     sqx_r, sqy_r;
  logic [SUM_W-1:0]    sum_r;
  logic                v1_r, v2_r;
  cfp_pkg::pipe_ctl_t  ctl_r;

  always_comb begin
    dx     = {pos_x[POS_BITS-1], pos_x} - {station_x[POS_BITS-1], station_x};
    dy     = {pos_y[POS_BITS-1], pos_y} - {station_y[POS_BITS-1], station_y};
    ndx    = -dx;
    ndy    = -dy;
    ax_nxt = dx[DW-1] ? ndx[POS_BITS-1:0] : dx[POS_BITS-1:0];
    ay_nxt = dy[DW-1] ? ndy[POS_BITS-1:0] : dy[POS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      ctl_r <= '0;
    end else if (adv) begin
      v1_r       <= in_valid;
      v2_r       <= v1_r;
      ctl_r.valid <= v2_r;
      ctl_r.zero  <= (sqx_r == '0) && (sqy_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      sqx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
      sqy_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
      sum_r <= SUM_W'(sqx_r) + SUM_W'(sqy_r);
    end
  end

  assign ctl_o = ctl_r;
  assign sum_o = sum_r;

endmodule

FILE: rtl/cfp_log2.sv
// Pipelined log2: leading-one search, normalize, one squaring stage per fraction bit.
module cfp_log2 #(
  parameter int POS_BITS      = 16,
  parameter int LOG_FRAC_BITS = 8
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            adv,
  input  cfp_pkg::pipe_ctl_t                              ctl_i,
  input  logic [2*POS_BITS:0]                             sum_i,
  output cfp_pkg::pipe_ctl_t                              ctl_o,
  output logic [$clog2(2*POS_BITS+1)+LOG_FRAC_BITS-1:0]   l2_o
);

  localparam int SUM_W = 2 * POS_BITS + 1;
  localparam int NB    = $clog2(SUM_W);
  localparam int F     = LOG_FRAC_BITS;
  localparam int MW    = cfp_pkg::MANT_W;
  localparam int SH_W  = SUM_W + cfp_pkg::MANT_FRAC;

  logic [NB-1:0]      msb;
  logic [NB-1:0]      n_a_r;
  logic [SUM_W-1:0]   sum_a_r;
  cfp_pkg::pipe_ctl_t ctl_a_r;
  logic [SH_W-1:0]    shifted;

  logic [MW-1:0]      m_r    [F+1];
  logic [F-1:0]       frac_r [F+1];
  logic [NB-1:0]      n_r    [F+1];
  cfp_pkg::pipe_ctl_t ctl_r  [F+1];

  always_comb begin
    msb = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (sum_i[i]) begin
        msb = NB'(i);
      end
    end
  end

  always_comb begin
    shifted = {sum_a_r, {cfp_pkg::MANT_FRAC{1'b0}}} >> n_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r  <= '0;
      ctl_r[0] <= '0;
    end else if (adv) begin
      ctl_a_r  <= ctl_i;
      ctl_r[0] <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_a_r     <= msb;
      sum_a_r   <= sum_i;
      m_r[0]    <= shifted[MW-1:0];
      n_r[0]    <= n_a_r;
      frac_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_frac
    logic [2*MW-1:0] sq;
    logic            bit_k;

    always_comb begin
      sq    = (2*MW)'(m_r[k]) * (2*MW)'(m_r[k]);
      bit_k = sq[2*MW-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (adv) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[k+1]    <= bit_k ? sq[2*MW-1:MW] : sq[2*MW-2:MW-1];
        frac_r[k+1] <= {frac_r[k][F-2:0], bit_k};
        n_r[k+1]    <= n_r[k];
      end
    end
  end

  assign ctl_o = ctl_r[F];
  assign l2_o  = {n_r[F], frac_r[F]};

endmodule

FILE: rtl/cfp_quality.sv
// Path loss scaling, link budget and saturation into the CQI result register.
module cfp_quality #(
  parameter int POS_BITS      = 16,
  parameter int LOG_FRAC_BITS = 8
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            adv,
  input  cfp_pkg::pipe_ctl_t                              ctl_i,
  input  logic [$clog2(2*POS_BITS+1)+LOG_FRAC_BITS-1:0]   l2_i,
  input  cfp_pkg::qual_cfg_t                              qcfg,
  output logic                                            valid_o,
  output logic [cfp_pkg::QUALITY_W-1:0]                   quality_o,
  output logic                                            clamped_o
);

  localparam int F     = LOG_FRAC_BITS;
  localparam int NB    = $clog2(2 * POS_BITS + 1);
  localparam int L2_W  = NB + F;
  localparam int T_W   = L2_W + 1;
  localparam int P1_W  = T_W + cfp_pkg::SLOPE_W + 1;
  localparam int P2_W  = P1_W + cfp_pkg::HLG_W + 1;
  localparam int BT_W  = cfp_pkg::BASE_W + F + cfp_pkg::BASE_SHIFT_EXTRA;
  localparam int NUM_W = ((P2_W > BT_W) ? P2_W : BT_W) + 1;
  localparam int RSH   = F + cfp_pkg::QSHIFT_EXTRA;
  localparam int RAW_W = NUM_W - RSH;
  localparam int QW    = cfp_pkg::QUALITY_W;

  localparam logic signed [T_W-1:0]   T_OFS   = T_W'(cfp_pkg::DIST_LOG_INT) << F;
  localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'(cfp_pkg::QUALITY_MAX);

  logic signed [T_W-1:0]   t;
  logic signed [P1_W-1:0]  prod1_nxt, prod1_r;
  logic signed [P2_W-1:0]  prod2_r;
  logic signed [NUM_W-1:0] num;
  logic signed [RAW_W-1:0] raw;
  cfp_pkg::pipe_ctl_t      c1_r, c2_r;
  logic                    valid_r;
  logic [QW-1:0]           quality_nxt, quality_r;
  logic                    clamped_nxt, clamped_r;

  always_comb begin
    t         = $signed({1'b0, l2_i}) - T_OFS;
    prod1_nxt = t * $signed({1'b0, qcfg.slope});
  end

  always_comb begin
    num = (NUM_W'(qcfg.base) <<< (F + cfp_pkg::BASE_SHIFT_EXTRA)) - NUM_W'(prod2_r);
    raw = $signed(num[NUM_W-1:RSH]);
    if (c2_r.zero) begin
      quality_nxt = cfp_pkg::QUALITY_MAX;
      clamped_nxt = 1'b1;
    end else if (raw[RAW_W-1]) begin
      quality_nxt = '0;
      clamped_nxt = 1'b1;
    end else if (raw > RAW_MAX) begin
      quality_nxt = cfp_pkg::QUALITY_MAX;
      clamped_nxt = 1'b1;
    end else begin
      quality_nxt = raw[QW-1:0];
      clamped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r    <= '0;
      c2_r    <= '0;
      valid_r <= 1'b0;
    end else if (adv) begin
      c1_r    <= ctl_i;
      c2_r    <= c1_r;
      valid_r <= c2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r   <= prod1_nxt;
      prod2_r   <= prod1_r * $signed({1'b0, cfp_pkg::HALF_LOG10_2_Q16});
      quality_r <= quality_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign valid_o   = valid_r;
  assign quality_o = quality_r;
  assign clamped_o = clamped_r;

endmodule

FILE: rtl/cqi_from_position.sv
// Top level: channel quality index from user position.
// Pipeline: LOG_FRAC_BITS + 8 register stages from request accept to result (16 at defaults).
// Throughput: one request per cycle when not stalled; one squaring stage per log2 fraction bit.
// Stall: a waiting result with out ready low freezes all stages together and drops in_ch.ready.
// Reset: synchronous active-low rst_n clears all valid bits and loads register defaults.
// Writes are always ready; station writes act next cycle, others also pass the qcfg register.
module cqi_from_position #(
  parameter int POS_BITS      = 16,
  parameter int LOG_FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  cfp_in_if.sink     in_ch,
  cfp_out_if.source  out_ch,
  cfp_cfg_if.sink    cfg_ch
);

  localparam int DATA_W = (POS_BITS > cfp_pkg::NOISE_W) ? POS_BITS : cfp_pkg::NOISE_W;
  localparam int NB     = $clog2(2 * POS_BITS + 1);

  logic                        adv;
  logic                        res_valid;
  logic [POS_BITS-1:0]         station_x, station_y;
  cfp_pkg::qual_cfg_t          qcfg;
  cfp_pkg::pipe_ctl_t          dist_ctl, log_ctl;
  logic [2*POS_BITS:0]         dist_sum;
  logic [NB+LOG_FRAC_BITS-1:0] l2;

  assign adv          = !res_valid || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = res_valid;

  cfp_regs #(.POS_BITS(POS_BITS), .DATA_W(DATA_W)) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_ch.valid),
    .wr_index  (cfg_ch.index),
    .wr_data   (DATA_W'(cfg_ch.data)),
    .station_x (station_x),
    .station_y (station_y),
    .qcfg      (qcfg)
  );

  cfp_dist #(.POS_BITS(POS_BITS)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .station_x (station_x),
    .station_y (station_y),
    .ctl_o     (dist_ctl),
    .sum_o     (dist_sum)
  );

  cfp_log2 #(.POS_BITS(POS_BITS), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (dist_ctl),
    .sum_i (dist_sum),
    .ctl_o (log_ctl),
    .l2_o  (l2)
  );

  cfp_quality #(.POS_BITS(POS_BITS), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_quality (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl_i     (log_ctl),
    .l2_i      (l2),
    .qcfg      (qcfg),
    .valid_o   (res_valid),
    .quality_o (out_ch.quality),
    .clamped_o (out_ch.clamped)
  );

endmodule

FILE: rtl/cfp_checker.sv
// Port-level checker for the position-to-CQI block and its bind.
module cfp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [cfp_pkg::QUALITY_W-1:0]  quality,
  input logic                           clamped
);

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(quality) && $stable(clamped))
    else $error("result changed while stalled");

  a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clamped |-> quality == '0 || quality == cfp_pkg::QUALITY_MAX)
    else $error("clamped result not at a range limit");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("request blocked while result side is free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind cqi_from_position cfp_checker u_cfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .quality   (out_ch.quality),
  .clamped   (out_ch.clamped)
);

FILE: dv/cqi_from_position_checker.sv
// Checker: predicts channel quality from observed requests and compares results.
`timescale 1ns / 1ps

module cqi_from_position_checker #(
  parameter int POS_BITS      = 16,
  parameter int LOG_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [POS_BITS-1:0]           in_pos_x,
  input  logic [POS_BITS-1:0]           in_pos_y,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [cfp_pkg::QUALITY_W-1:0] out_quality,
  input  logic                          out_clamped,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cfp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic [cfp_pkg::QUALITY_W-1:0] quality;
    logic                          clamped;
  } cqi_t;

  logic signed [POS_BITS-1:0]          sta_x;
  logic signed [POS_BITS-1:0]          sta_y;
  logic [cfp_pkg::TX_W-1:0]            tx_db;
  logic [cfp_pkg::REF_W-1:0]           ref_db;
  logic [cfp_pkg::SLOPE_W-1:0]         slope_db;
  logic signed [cfp_pkg::NOISE_W-1:0]  floor_lvl;
  logic signed [cfp_pkg::OFFSET_W-1:0] offset_db;

  cqi_t quality_q[$];

  function automatic longint unsigned log2_q(longint unsigned s);
    int unsigned      msb;
    int               b;
    longint unsigned  m;
    longint unsigned  frac;
    msb = 0;
    for (b = 0; b < 64; b++) begin
      if (s[b]) msb = b;
    end
    if (msb <= cfp_pkg::MANT_FRAC) m = s << (cfp_pkg::MANT_FRAC - msb);
    else m = s >> (msb - cfp_pkg::MANT_FRAC);
    frac = 0;
    for (b = 0; b < LOG_FRAC_BITS; b++) begin
      m = (m * m) >> cfp_pkg::MANT_FRAC;
      frac = frac << 1;
      if (m >= (64'd1 << cfp_pkg::MANT_W)) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (longint'(msb) << LOG_FRAC_BITS) | frac;
  endfunction

  function automatic cqi_t predict_cqi(logic signed [POS_BITS-1:0] px,
                                       logic signed [POS_BITS-1:0] py);
    longint          dx;
    longint          dy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned s;
    longint          t;
    longint          base;
    longint          num;
    longint          raw;
    cqi_t            r;
    dx = longint'(px) - longint'(sta_x);
    dy = longint'(py) - longint'(sta_y);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    s  = ax * ax + ay * ay;
    if (s == 0) begin
      r.quality = cfp_pkg::QUALITY_MAX;
      r.clamped = 1'b1;
      return r;
    end
    t = longint'(log2_q(s)) - (longint'(cfp_pkg::DIST_LOG_INT) << LOG_FRAC_BITS);
    base = longint'(tx_db) - longint'(floor_lvl) - longint'(offset_db) - longint'(ref_db);
    num = base * (64'sd1 <<< (LOG_FRAC_BITS + cfp_pkg::BASE_SHIFT_EXTRA))
        - longint'(slope_db) * t * longint'(cfp_pkg::HALF_LOG10_2_Q16);
    raw = num >>> (LOG_FRAC_BITS + cfp_pkg::QSHIFT_EXTRA);
    if (raw < 0) begin
      r.quality = '0;
      r.clamped = 1'b1;
    end else if (raw > longint'(cfp_pkg::QUALITY_MAX)) begin
      r.quality = cfp_pkg::QUALITY_MAX;
      r.clamped = 1'b1;
    end else begin
      r.quality = raw[cfp_pkg::QUALITY_W-1:0];
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  task automatic apply_write(logic [cfp_pkg::REG_IDX_W-1:0] idx, logic [15:0] v);
    case (idx)
      cfp_pkg::REG_STATION_X:   sta_x     = v[POS_BITS-1:0];
      cfp_pkg::REG_STATION_Y:   sta_y     = v[POS_BITS-1:0];
      cfp_pkg::REG_TX_POWER:    tx_db     = v[cfp_pkg::TX_W-1:0];
      cfp_pkg::REG_REFERENCE:   ref_db    = v[cfp_pkg::REF_W-1:0];
      cfp_pkg::REG_SLOPE:       slope_db  = v[cfp_pkg::SLOPE_W-1:0];
      cfp_pkg::REG_NOISE_FLOOR: floor_lvl = v[cfp_pkg::NOISE_W-1:0];
      cfp_pkg::REG_SINR_OFFSET: offset_db = v[cfp_pkg::OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cqi_t want;
    if (!rst_n) begin
      sta_x      = '0;
      sta_y      = '0;
      tx_db      = cfp_pkg::TX_RESET;
      ref_db     = cfp_pkg::REF_RESET;
      slope_db   = cfp_pkg::SLOPE_RESET;
      floor_lvl  = cfp_pkg::NOISE_RESET;
      offset_db  = cfp_pkg::OFFSET_RESET;
      fail_count = 0;
      quality_q.delete();
    end else begin
      if (in_valid && in_ready) quality_q.push_back(predict_cqi(in_pos_x, in_pos_y));
      if (out_valid && out_ready) begin
        if (quality_q.size() == 0) begin
          $error("result with no pending request: quality %0d clamped %0d",
                 out_quality, out_clamped);
          fail_count = fail_count + 1;
        end else begin
          want = quality_q.pop_front();
          if (out_quality !== want.quality) begin
            $error("quality: expected %0d, actual %0d", want.quality, out_quality);
            fail_count = fail_count + 1;
          end
          if (out_clamped !== want.clamped) begin
            $error("clamped: expected %0d, actual %0d", want.clamped, out_clamped);
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
    end
    pending <= quality_q.size();
  end

endmodule

FILE: dv/cqi_from_position_test.sv
// Testbench top: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module cqi_from_position_test;

  localparam int POS_BITS      = 16;
  localparam int LOG_FRAC_BITS = 8;
  localparam int DRAIN_CYCLES  = LOG_FRAC_BITS + 8 + 4;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [cfp_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {CFG_TYPICAL, CFG_RAW_BITS, CFG_EXTREME} cfg_style_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;

  logic [POS_BITS-1:0] cur_sx;
  logic [POS_BITS-1:0] cur_sy;

  cfp_in_if #(.POS_BITS(POS_BITS)) in_ch();
  cfp_out_if                       out_ch();
  cfp_cfg_if #(.DATA_W(16))        cfg_ch();

  cqi_from_position #(
    .POS_BITS(POS_BITS),
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  cqi_from_position_checker #(
    .POS_BITS(POS_BITS),
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_pos_x(in_ch.pos_x),
    .in_pos_y(in_ch.pos_y),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_quality(out_ch.quality),
    .out_clamped(out_ch.clamped),
    .cfg_valid(cfg_ch.valid),
    .cfg_ready(cfg_ch.ready),
    .cfg_index(cfg_ch.index),
    .cfg_data(cfg_ch.data),
    .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic put_position(logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] y);
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic cfg_write(logic [cfp_pkg::REG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(logic [15:0] sx, logic [15:0] sy, logic [15:0] tx,
                           logic [15:0] refl, logic [15:0] slope, logic [15:0] noise,
                           logic [15:0] offset);
    cur_sx = sx;
    cur_sy = sy;
    cfg_write(cfp_pkg::REG_STATION_X, sx);
    cfg_write(cfp_pkg::REG_STATION_Y, sy);
    cfg_write(cfp_pkg::REG_TX_POWER, tx);
    cfg_write(cfp_pkg::REG_REFERENCE, refl);
    cfg_write(cfp_pkg::REG_SLOPE, slope);
    cfg_write(cfp_pkg::REG_NOISE_FLOOR, noise);
    cfg_write(cfp_pkg::REG_SINR_OFFSET, offset);
  endtask

  function automatic logic [15:0] pick2(logic [15:0] a, logic [15:0] b);
    return ($urandom_range(0, 1) != 0) ? a : b;
  endfunction

  task automatic set_config(cfg_style_t style);
    case (style)
      CFG_RAW_BITS: begin
        write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
      end
      CFG_EXTREME: begin
        write_all(pick2(16'h8000, 16'h7FFF), pick2(16'h8000, 16'h7FFF), pick2(16'd0, 16'd63),
                  pick2(16'd0, 16'd127), pick2(16'd0, 16'd63), pick2(16'hFF60, 16'd0),
                  pick2(16'hFFC0, 16'd127));
      end
      default: begin
        write_all(16'($urandom_range(0, 40000) - 20000), 16'($urandom_range(0, 40000) - 20000),
                  16'($urandom_range(30, 63)), 16'($urandom_range(20, 60)),
                  16'($urandom_range(20, 45)), 16'(-int'($urandom_range(80, 120))),
                  16'(int'($urandom_range(0, 50)) - 10));
      end
    endcase
    if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, 16'($urandom));
  endtask

  function automatic logic [15:0] pick_coord(logic [15:0] center);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 4: return center + 16'($urandom_range(0, 8191)) - 16'd4096;
      5, 6:          return center + 16'($urandom_range(0, 127)) - 16'd64;
      7, 8:          return 16'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return center;
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned out_hold;
    int unsigned k;
    forever begin
      case ($urandom_range(0, 9))
        0, 1: begin
          out_ch.ready <= 1'b1;
          repeat ($urandom_range(20, 200)) @(posedge clk);
        end
        2, 3: begin
          out_hold = $urandom_range(10, 40);
          for (k = 0; k < out_hold; k++) begin
            out_ch.ready <= k[0];
            @(posedge clk);
          end
        end
        default: begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      endcase
    end
  end

  initial begin
    int          phase;
    int          sent;
    int unsigned burst;
    int unsigned k;
    bit          steady;
    cfg_style_t  style;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.pos_x  <= '0;
    in_ch.pos_y  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= cfp_pkg::REG_STATION_X;
    cfg_ch.data  <= '0;
    cur_sx = '0;
    cur_sy = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: zero distance, one quarter metre, corners, one metre, mid range
    put_position(16'h0000, 16'h0000);
    put_position(16'h0001, 16'h0000);
    put_position(16'h7FFF, 16'h7FFF);
    put_position(16'h8000, 16'h8000);
    put_position(16'h8000, 16'h7FFF);
    put_position(16'h0004, 16'h0000);
    put_position(16'd400, 16'd300);
    put_position(16'h0000, 16'(-4000));
    drain;

    // farthest user from a corner station, high link budget
    write_all(16'h7FFF, 16'h8000, 16'd63, 16'd0, 16'd0, 16'hFF60, 16'hFFC0);
    cfg_write(REG_UNUSED, 16'h1234);
    put_position(16'h8000, 16'h7FFF);
    put_position(16'h7FFF, 16'h8000);
    put_position(16'h0000, 16'h0000);
    drain;

    // quality of exactly 15.0, exactly zero, and just below zero
    write_all(16'h0000, 16'h0000, 16'd60, 16'd0, 16'd0, 16'd0, 16'd0);
    put_position(16'd100, 16'd100);
    drain;
    cfg_write(cfp_pkg::REG_TX_POWER, 16'd0);
    put_position(16'd100, 16'd100);
    drain;
    cfg_write(cfp_pkg::REG_REFERENCE, 16'd1);
    put_position(16'd100, 16'd100);
    drain;

    // noise and offset patterns outside the nominal range
    write_all(16'h0000, 16'h0000, 16'd0, 16'd127, 16'd63, 16'h00FF, 16'd127);
    put_position(16'h8000, 16'h8000);
    drain;
    write_all(16'h0000, 16'h0000, 16'd63, 16'd0, 16'd63, 16'h0100, 16'h0080);
    put_position(16'd40, 16'd0);
    put_position(16'h8000, 16'h7FFF);
    drain;

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 3) style = CFG_RAW_BITS;
      else if (phase == 6) style = CFG_EXTREME;
      else style = CFG_TYPICAL;
      set_config(style);
      steady = (phase % 3 == 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          put_position(pick_coord(cur_sx), pick_coord(cur_sy));
          sent++;
        end
        if (!steady && $urandom_range(0, 3) != 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      drain;
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
